// File: src/b64dl_pkg.sv
// Shared types, constants and the character table of the lenient base64 decoder.
package b64dl_pkg;

  localparam logic [7:0] PadChar     = 8'h3D;
  localparam int         QueueDepth  = 8;
  localparam int         QueueAw     = $clog2(QueueDepth);
  localparam int         GroupMax    = 3;

  // One decoded byte with its flags
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } b64dl_res_t;

  // Bytes produced by one accepted character
  typedef struct packed {
    logic [1:0]            count;
    b64dl_res_t [2:0]      res;
  } b64dl_group_t;

  // Map a text character to its 6-bit value; unknown codes and pad give 0
  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [5:0] v;
    v = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B || c == 8'h2D || c == 8'h2E) begin
      v = 6'd62;
    end else if (c == 8'h2F || c == 8'h2C || c == 8'h5F) begin
      v = 6'd63;
    end
    return v;
  endfunction

endpackage

// File: src/b64dl_unpack.sv
// Group state and byte assembly: turns one character into zero to three bytes.
module b64dl_unpack (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            in_char,
  input  logic                  in_last,
  output b64dl_pkg::b64dl_group_t group
);
  import b64dl_pkg::*;

  logic [1:0] group_fill;
  logic [1:0] group_fill_next;
  logic       third_was_pad;
  logic       third_was_pad_next;
  logic [5:0] held_sextets [GroupMax];
  logic [5:0] v;
  logic [5:0] a;
  logic [5:0] b;
  logic [5:0] d;
  logic       is_pad;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;

  assign v      = sextet_of(in_char);
  assign a      = held_sextets[0];
  assign b      = held_sextets[1];
  assign d      = held_sextets[2];
  assign is_pad = (in_char == PadChar);
  assign byte0  = {a, b[5:4]};
  assign byte1  = {b[3:0], d[5:2]};
  assign byte2  = {d[1:0], v};

  // Assemble the bytes this character releases
  always_comb begin
    group              = '0;
    group_fill_next    = 2'd0;
    third_was_pad_next = 1'b0;
    if (!in_last) begin
      third_was_pad_next = third_was_pad;
      if (group_fill == 2'd3) begin
        group.count  = 2'd3;
        group.res[0] = '{data: byte0, last: 1'b0, bad: 1'b0};
        group.res[1] = '{data: byte1, last: 1'b0, bad: 1'b0};
        group.res[2] = '{data: byte2, last: 1'b0, bad: 1'b0};
      end else begin
        group_fill_next = group_fill + 2'd1;
        if (group_fill == 2'd2) begin
          third_was_pad_next = is_pad;
        end
      end
    end else begin
      unique case (group_fill)
        2'd0: begin
          // single leftover character
          group.count  = 2'd1;
          group.res[0] = '{data: {v, 2'b00}, last: 1'b1, bad: 1'b1};
        end
        2'd1: begin
          group.count  = 2'd1;
          group.res[0] = '{data: {a, v[5:4]}, last: 1'b1, bad: 1'b0};
        end
        2'd2: begin
          group.count  = 2'd2;
          group.res[0] = '{data: byte0, last: 1'b0, bad: 1'b0};
          group.res[1] = '{data: {b[3:0], v[5:2]}, last: 1'b1, bad: 1'b0};
        end
        default: begin
          if (is_pad && third_was_pad) begin
            group.count  = 2'd1;
            group.res[0] = '{data: byte0, last: 1'b1, bad: 1'b0};
          end else if (is_pad) begin
            group.count  = 2'd2;
            group.res[0] = '{data: byte0, last: 1'b0, bad: 1'b0};
            group.res[1] = '{data: byte1, last: 1'b1, bad: 1'b0};
          end else begin
            group.count  = 2'd3;
            group.res[0] = '{data: byte0, last: 1'b0, bad: 1'b0};
            group.res[1] = '{data: byte1, last: 1'b0, bad: 1'b0};
            group.res[2] = '{data: byte2, last: 1'b1, bad: 1'b0};
          end
        end
      endcase
    end
  end

  // Advance group control state
  always_ff @(posedge clk) begin
    if (rst) begin
      group_fill    <= 2'd0;
      third_was_pad <= 1'b0;
    end else if (take) begin
      group_fill    <= group_fill_next;
      third_was_pad <= third_was_pad_next;
    end
  end

  // Hold the sextets of a partial group
  always_ff @(posedge clk) begin
    if (take && !in_last) begin
      unique case (group_fill)
        2'd0:    held_sextets[0] <= v;
        2'd1:    held_sextets[1] <= v;
        2'd2:    held_sextets[2] <= v;
        default: ;
      endcase
    end
  end

endmodule

// File: src/base64_decoder_lenient_core.sv
// Top level of the lenient base64 decoder: character input, byte output queue.
//
// Usage:
//   Character channel (char_valid, char_stall, in_char, in_last) takes one text
//   character per word; in_last marks the final character of a stream.
//   Byte channel (byte_valid, byte_stall, out_byte, out_last, tail_malformed)
//   gives one decoded byte per word. out_last marks the final byte of the
//   stream; tail_malformed marks the byte made from a lone leftover character.
//   The bytes a character releases are written into an 8-entry output queue
//   at the edge accepting it; from an empty queue the first shows next cycle.
//   With no stall: one character per cycle. A group of four characters gives
//   three bytes, drained at one byte per cycle, so the queue keeps pace.
//   char_stall rises only while the queue has fewer than three free entries,
//   which happens when the receiver holds byte_stall high.
//   A stalled byte holds its value until taken.
//   Reset (rst, synchronous) empties the queue and the partial group; no
//   clearing pass is needed.
module base64_decoder_lenient_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       byte_valid,
  input  logic       byte_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       tail_malformed
);
  import b64dl_pkg::*;

  logic                   take;
  logic                   pop;
  b64dl_group_t           group;
  b64dl_res_t             queue [QueueDepth];
  logic [QueueAw-1:0]     wr_ptr;
  logic [QueueAw-1:0]     rd_ptr;
  logic [QueueAw:0]       fill;
  logic [QueueAw:0]       fill_next;
  logic [1:0]             push_count;
  b64dl_res_t             head;

  b64dl_unpack u_unpack (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_char (in_char),
    .in_last (in_last),
    .group   (group)
  );

  // Stall while fewer than three entries are free
  assign char_stall = (fill > (QueueAw + 1)'(QueueDepth - GroupMax));
  assign take       = char_valid && !char_stall;
  assign pop        = byte_valid && !byte_stall;
  assign push_count = take ? group.count : 2'd0;
  assign fill_next  = fill + (QueueAw + 1)'(push_count) - (QueueAw + 1)'(pop);

  // Present the head of the queue
  assign head           = queue[rd_ptr];
  assign byte_valid     = (fill != '0);
  assign out_byte       = head.data;
  assign out_last       = head.last;
  assign tail_malformed = head.bad;

  // Advance queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + QueueAw'(push_count);
      rd_ptr <= rd_ptr + QueueAw'(pop);
      fill   <= fill_next;
    end
  end

  // Write up to three bytes into consecutive slots
  always_ff @(posedge clk) begin
    if (take) begin
      if (group.count > 2'd0) begin
        queue[wr_ptr] <= group.res[0];
      end
      if (group.count > 2'd1) begin
        queue[wr_ptr + QueueAw'(1)] <= group.res[1];
      end
      if (group.count > 2'd2) begin
        queue[wr_ptr + QueueAw'(2)] <= group.res[2];
      end
    end
  end

endmodule

// File: src/b64dl_checker.sv
// Port-level checks for the lenient base64 decoder, bound to the top level.
module b64dl_checker (
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_stall,
  input logic       in_last,
  input logic       byte_valid,
  input logic       byte_stall,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       tail_malformed
);

  // Reset empties the queue and opens the input
  a_reset_empty: assert property (@(posedge clk) rst |=> !byte_valid && !char_stall)
    else $error("queue not empty after reset");

  // A malformed tail byte always ends its stream
  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    byte_valid && tail_malformed |-> out_last)
    else $error("malformed byte without last flag");

  // A stalled byte holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(out_byte)
      && $stable(out_last) && $stable(tail_malformed))
    else $error("stalled byte changed");

  // An accepted last character always releases at least one byte
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && in_last |=> byte_valid)
    else $error("no byte after last character");

  // With the output side idle, the input never stalls
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !byte_valid |-> !char_stall)
    else $error("input stalled with empty queue");

endmodule

bind base64_decoder_lenient_core b64dl_checker u_b64dl_checker (
  .clk            (clk),
  .rst            (rst),
  .char_valid     (char_valid),
  .char_stall     (char_stall),
  .in_last        (in_last),
  .byte_valid     (byte_valid),
  .byte_stall     (byte_stall),
  .out_byte       (out_byte),
  .out_last       (out_last),
  .tail_malformed (tail_malformed)
);
